// ===== src/dirty_buffer_list_manager_core_macros.svh =====
// Assertion macros for the dirty buffer list manager core.
// Expects clk and rst in the including scope.
`ifndef DIRTY_BUFFER_LIST_MANAGER_CORE_MACROS_SVH
`define DIRTY_BUFFER_LIST_MANAGER_CORE_MACROS_SVH

// property that holds on every cycle outside reset
`define DBLM_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition in one cycle implies a consequence in the next
`define DBLM_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ===== src/dblm_pkg.sv =====
// Package for the dirty buffer list manager: item types, mode and status codes.
// No dependencies.
package dblm_pkg;

  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_REMOVE  = 2'd1;
  localparam logic [1:0] MODE_READOUT = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_LISTED     = 3'd1;
  localparam logic [2:0] ST_NOT_LISTED = 3'd2;
  localparam logic [2:0] ST_EMPTY      = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED  = 3'd4;

  localparam logic [6:0] COUNT_MAX = 7'd127;
  localparam logic [5:0] WALK_LAST = 6'd63;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  list_id;
    logic [6:0]  buffer_id;
    logic [31:0] block_number;
  } dblm_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  out_buffer;
    logic [31:0] out_block;
    logic [6:0]  list_length;
    logic        last;
  } dblm_rsp_t;

endpackage

// ===== src/dirty_buffer_list_manager_core.sv =====
// Dirty buffer list manager: doubly linked lists in a shared node pool.
// Depends on dblm_pkg and dirty_buffer_list_manager_core_macros.svh.
// After reset a clearing pass initializes the list table, the free stack and
// the buffer slots; no item is taken then.
// One item at a time: every item passes through S_Q, S_R, S_RD and S_EV; an
// insert behind a tail adds S_LINK, a remove adds S_RM1 to S_RM3, and a
// read-out passes S_WK and S_WE once per element emitted, since
// each element is one registered read of the node memory. A pending result
// does not block accepting the next item, but a stalled one holds it in S_EV, S_RM3 or S_WE.
module dirty_buffer_list_manager_core #(
  parameter int BUFFERS = 64,
  parameter int NODES   = 256,
  parameter int LISTS   = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  dblm_pkg::dblm_req_t  req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output dblm_pkg::dblm_rsp_t  rsp
);
  import dblm_pkg::*;

  localparam int NW   = $clog2(NODES);
  localparam int LW   = $clog2(NODES + 1);
  localparam int BW   = $clog2(BUFFERS);
  localparam int LIW  = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int MAXA = (LISTS > NODES) ? LISTS : NODES;
  localparam int MAXD = (MAXA > BUFFERS) ? MAXA : BUFFERS;
  localparam int ICW  = $clog2(MAXD + 1);
  localparam int RS   = 20;
  localparam int RECIP = (1 << RS) / LISTS;
  localparam int RW   = RS + 1;
  localparam int PW   = 10 + RW;
  localparam int QW   = PW - RS;
  localparam int MW   = QW + 17;

  localparam logic [LW-1:0] NIL = {LW{1'b1}};

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_Q    = 4'd2;
  localparam logic [3:0] S_R    = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_EV   = 4'd5;
  localparam logic [3:0] S_LINK = 4'd6;
  localparam logic [3:0] S_RM1  = 4'd7;
  localparam logic [3:0] S_RM2  = 4'd8;
  localparam logic [3:0] S_RM3  = 4'd9;
  localparam logic [3:0] S_WK   = 4'd10;
  localparam logic [3:0] S_WE   = 4'd11;

  function automatic logic vld(input logic [LW-1:0] x);
    return x < LW'(NODES);
  endfunction

  // memories
  logic [LW-1:0] lhead [LISTS];
  logic [LW-1:0] ltail [LISTS];
  logic [6:0]    lcnt  [LISTS];
  logic [LW-1:0] slot  [BUFFERS];
  logic [LW-1:0] nprev [NODES];
  logic [LW-1:0] nnext [NODES];
  logic [6:0]    nbuf  [NODES];
  logic [31:0]   nblk  [NODES];

  logic [LW-1:0] lhead_q, ltail_q, slot_q, nprev_q, nnext_q;
  logic [6:0]    lcnt_q, nbuf_q;
  logic [31:0]   nblk_q;

  // control and item registers
  logic [3:0]     state;
  logic [ICW-1:0] ic;
  logic [LW-1:0]  ftop;
  logic           ovalid;
  dblm_rsp_t      orsp;
  dblm_req_t      r;
  logic [PW-1:0]  prod;
  logic [MW-1:0]  qm;
  logic [LIW-1:0] lidx;
  logic [NW-1:0]  nsel;
  logic [NW-1:0]  link_t;
  logic [LW-1:0]  link_n;
  logic [6:0]     lcnt_r;
  logic [5:0]     k;

  // write ports
  logic           l_we, s_we, p_we, x_we, d_we;
  logic [LIW-1:0] l_wa;
  logic [BW-1:0]  s_wa;
  logic [NW-1:0]  p_wa, x_wa, d_wa;
  logic [LW-1:0]  lh_wd, lt_wd, s_wd, p_wd, x_wd;
  logic [6:0]     lc_wd, db_wd;
  logic [31:0]    dk_wd;

  logic          ofree, brange, link, ins_ok, wlast;
  logic [BW-1:0] bidx;
  logic [6:0]    cnt_inc, cnt_dec;
  logic [LW-1:0] nsel_l;
  logic [MW-1:0] rem;
  logic [ICW:0]  ic_inc;

  assign ofree     = !ovalid || !rsp_stall;
  assign req_stall = (state != S_IDLE);
  assign rsp_valid = ovalid;
  assign rsp       = orsp;
  assign brange    = (r.buffer_id != 7'd0) && (r.buffer_id <= 7'(BUFFERS));
  assign bidx      = BW'(r.buffer_id - 7'd1);
  assign link      = (lhead_q != NIL) && vld(ltail_q);
  assign ins_ok    = (r.mode == MODE_INSERT) && brange && !vld(slot_q) && vld(ftop)
                     && vld(nprev_q);
  assign cnt_inc   = (lcnt_q == COUNT_MAX) ? lcnt_q : lcnt_q + 7'd1;
  assign cnt_dec   = (lcnt_q == 7'd0) ? lcnt_q : lcnt_q - 7'd1;
  assign nsel_l    = LW'(nsel);
  assign wlast     = !vld(nnext_q) || (k == WALK_LAST);
  assign rem       = MW'(r.list_id) - qm;
  assign ic_inc    = {1'b0, ic} + 1'b1;

  always_ff @(posedge clk) begin
    lhead_q <= lhead[lidx];
    ltail_q <= ltail[lidx];
    lcnt_q  <= lcnt[lidx];
    slot_q  <= slot[bidx];
    nprev_q <= nprev[nsel];
    nnext_q <= nnext[nsel];
    nbuf_q  <= nbuf[nsel];
    nblk_q  <= nblk[nsel];
    if (l_we) begin
      lhead[l_wa] <= lh_wd;
      ltail[l_wa] <= lt_wd;
      lcnt[l_wa]  <= lc_wd;
    end
    if (s_we) begin
      slot[s_wa] <= s_wd;
    end
    if (p_we) begin
      nprev[p_wa] <= p_wd;
    end
    if (x_we) begin
      nnext[x_wa] <= x_wd;
    end
    if (d_we) begin
      nbuf[d_wa] <= db_wd;
      nblk[d_wa] <= dk_wd;
    end
  end

  always_comb begin
    l_we = 1'b0; l_wa = lidx; lh_wd = lhead_q; lt_wd = ltail_q; lc_wd = lcnt_q;
    s_we = 1'b0; s_wa = bidx; s_wd = NIL;
    p_we = 1'b0; p_wa = nsel; p_wd = NIL;
    x_we = 1'b0; x_wa = nsel; x_wd = NIL;
    d_we = 1'b0; d_wa = nsel; db_wd = 7'd0; dk_wd = 32'd0;
    case (state)
      S_INIT: begin
        l_we  = (ic < ICW'(LISTS));
        l_wa  = ic[LIW-1:0];
        lh_wd = NIL;
        lt_wd = NIL;
        lc_wd = 7'd0;
        s_we  = (ic < ICW'(BUFFERS));
        s_wa  = ic[BW-1:0];
        p_we  = (ic < ICW'(NODES));
        p_wa  = ic[NW-1:0];
        p_wd  = (ic_inc < (ICW+1)'(NODES)) ? LW'(ic_inc) : NIL;
      end
      S_EV: begin
        if (ofree && ins_ok) begin
          p_we  = 1'b1;
          p_wa  = ftop[NW-1:0];
          p_wd  = link ? ltail_q : NIL;
          x_we  = 1'b1;
          x_wa  = ftop[NW-1:0];
          d_we  = 1'b1;
          d_wa  = ftop[NW-1:0];
          db_wd = r.buffer_id;
          dk_wd = r.block_number;
          l_we  = 1'b1;
          lh_wd = link ? lhead_q : ftop;
          lt_wd = ftop;
          lc_wd = cnt_inc;
          s_we  = 1'b1;
          s_wd  = ftop;
        end else if (ofree && r.mode == MODE_REMOVE && brange && vld(slot_q)) begin
          s_we = 1'b1;
        end
      end
      S_LINK: begin
        x_we = 1'b1;
        x_wa = link_t;
        x_wd = link_n;
      end
      S_RM2: begin
        l_we  = 1'b1;
        lc_wd = cnt_dec;
        if (lhead_q == nsel_l && ltail_q == nsel_l) begin
          lh_wd = NIL;
          lt_wd = NIL;
        end else if (lhead_q == nsel_l) begin
          lh_wd = nnext_q;
          p_we  = vld(nnext_q);
          p_wa  = nnext_q[NW-1:0];
        end else if (ltail_q == nsel_l) begin
          lt_wd = nprev_q;
          x_we  = vld(nprev_q);
          x_wa  = nprev_q[NW-1:0];
        end else begin
          x_we = vld(nprev_q);
          x_wa = nprev_q[NW-1:0];
          x_wd = nnext_q;
          p_we = vld(nnext_q);
          p_wa = nnext_q[NW-1:0];
          p_wd = nprev_q;
        end
      end
      S_RM3: begin
        if (ofree) begin
          d_we = 1'b1;
          x_we = 1'b1;
          x_wd = '0;
          p_we = 1'b1;
          p_wd = ftop;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      ic     <= '0;
      ftop   <= '0;
      ovalid <= 1'b0;
    end else begin
      if (ovalid && !rsp_stall) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          ic <= ic_inc[ICW-1:0];
          if (ic_inc == (ICW+1)'(MAXD)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            r     <= req;
            prod  <= PW'(req.list_id) * PW'(RECIP);
            state <= S_Q;
          end
        end
        S_Q: begin
          qm    <= MW'(prod[PW-1:RS]) * MW'(LISTS);
          state <= S_R;
        end
        S_R: begin
          lidx  <= (rem >= MW'(LISTS)) ? LIW'(rem - MW'(LISTS)) : LIW'(rem);
          nsel  <= ftop[NW-1:0];
          state <= S_RD;
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          if (ofree) begin
            orsp.out_buffer  <= 7'd0;
            orsp.out_block   <= 32'd0;
            orsp.list_length <= lcnt_q;
            orsp.last        <= 1'b1;
            orsp.status      <= ST_OK;
            ovalid           <= 1'b1;
            state            <= S_IDLE;
            case (r.mode)
              MODE_INSERT: begin
                if (!brange) begin
                  orsp.status <= ST_NOT_LISTED;
                end else if (vld(slot_q)) begin
                  orsp.status <= ST_LISTED;
                end else if (!ins_ok) begin
                  orsp.status <= ST_EXHAUSTED;
                end else begin
                  orsp.list_length <= cnt_inc;
                  ftop   <= nprev_q;
                  link_t <= ltail_q[NW-1:0];
                  link_n <= ftop;
                  if (link) begin
                    state <= S_LINK;
                  end
                end
              end
              MODE_REMOVE: begin
                if (brange && vld(slot_q)) begin
                  ovalid <= 1'b0;
                  nsel   <= slot_q[NW-1:0];
                  state  <= S_RM1;
                end else begin
                  orsp.status <= ST_NOT_LISTED;
                end
              end
              MODE_READOUT: begin
                if (lcnt_q == 7'd0 || !vld(lhead_q)) begin
                  orsp.status <= ST_EMPTY;
                end else begin
                  ovalid <= 1'b0;
                  nsel   <= lhead_q[NW-1:0];
                  lcnt_r <= lcnt_q;
                  k      <= '0;
                  state  <= S_WK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_LINK: begin
          state <= S_IDLE;
        end
        S_RM1: begin
          state <= S_RM2;
        end
        S_RM2: begin
          lcnt_r <= cnt_dec;
          state  <= S_RM3;
        end
        S_RM3: begin
          if (ofree) begin
            orsp.status      <= ST_OK;
            orsp.out_buffer  <= 7'd0;
            orsp.out_block   <= 32'd0;
            orsp.list_length <= lcnt_r;
            orsp.last        <= 1'b1;
            ovalid           <= 1'b1;
            ftop             <= nsel_l;
            state            <= S_IDLE;
          end
        end
        S_WK: begin
          state <= S_WE;
        end
        S_WE: begin
          if (ofree) begin
            orsp.status      <= ST_OK;
            orsp.out_buffer  <= nbuf_q;
            orsp.out_block   <= nblk_q;
            orsp.list_length <= lcnt_r;
            orsp.last        <= wlast;
            ovalid           <= 1'b1;
            k                <= k + 6'd1;
            nsel             <= nnext_q[NW-1:0];
            state            <= wlast ? S_IDLE : S_WK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "dirty_buffer_list_manager_core_macros.svh"

  `DBLM_CHECK(a_ftop_valid, (state != S_INIT) |-> vld(ftop), "free stack top invalid")
  `DBLM_CHECK(a_init_quiet, (state == S_INIT) |-> !ovalid, "result during clearing pass")
  `DBLM_CHECK(a_empty_last, (ovalid && orsp.status == ST_EMPTY) |-> (orsp.last && orsp.out_buffer == 7'd0), "empty read-out not final")
  `DBLM_NEXT(a_ins_pop, (state == S_EV) && ofree && ins_ok, ftop != $past(ftop), "insert did not pop free stack")

endmodule
